// ----- hw/rtl/flash_block_stager_crc32_defines.svh -----
// ----------------------------------------------------------------------------
// Flash block stager assertion macros
// Shared assertion wrappers, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FLASH_BLOCK_STAGER_CRC32_DEFINES_SVH
`define FLASH_BLOCK_STAGER_CRC32_DEFINES_SVH

// Check a property on every clock edge outside reset
`define FBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another one on the next edge
`define FBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/fbs_pkg.sv -----
// ----------------------------------------------------------------------------
// Flash block stager package
// Request and result types, codes and queue sizing shared by the stager.
// ----------------------------------------------------------------------------
`default_nettype none

package fbs_pkg;

  // Request kinds
  typedef enum logic [1:0] {
    MODE_BEGIN  = 2'd0,
    MODE_DATA   = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_ABORT  = 2'd3
  } mode_e;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_STATUS     = 3'd0,
    KIND_ERASE_PART = 3'd1,
    KIND_WRITE      = 3'd2,
    KIND_ERASE_META = 3'd3,
    KIND_COMMIT     = 3'd4
  } kind_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_EXPECTED_SIZE  = 2'd0,
    CFG_PARTITION_SIZE = 2'd1,
    CFG_WRITE_BLOCK    = 2'd2,
    CFG_ERASED_FILL    = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgWidth = 25;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  data_byte;
  } req_t;

  typedef struct packed {
    kind_e        kind;
    logic [23:0]  flash_offset;
    logic [63:0]  block_data;
    logic [24:0]  image_size;
    logic [31:0]  image_crc;
    logic         ok;
    logic         last;
  } res_t;

  // Results produced by one request, in order
  typedef struct packed {
    logic [1:0]  cnt;
    res_t        r0;
    res_t        r1;
  } push_t;

endpackage

`default_nettype wire

// ----- hw/rtl/flash_block_stager_crc32.sv -----
// A request's first result is shown at the earliest the cycle after it is accepted.
// Throughput: one request per cycle while each gives one result and the sink keeps up;
//   a finish with an open block gives two results, which leave one after the other.
// in_ready_o is set by the four-entry result queue, which must hold two free slots.
// Reset clears the session, the latched program unit and the queue at once;
//   write_block_bytes returns to 4 and erased_fill to 0xFF. No clearing pass.
// ----------------------------------------------------------------------------
// Flash block stager with CRC-32
// Checks a staging session, packs image bytes into flash program blocks,
// keeps a running CRC-32 and issues erase, write and commit results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "flash_block_stager_crc32_defines.svh"

module flash_block_stager_crc32 #(
  parameter int unsigned METADATA_BYTES  = 256,
  parameter int unsigned MAX_BLOCK_BYTES = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  fbs_pkg::req_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output fbs_pkg::res_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  fbs_pkg::cfg_idx_e              cfg_index_i,
  input  logic [fbs_pkg::CfgWidth-1:0]   cfg_wdata_i
);
  import fbs_pkg::*;

  localparam logic [25:0] MdW     = 26'(METADATA_BYTES);
  localparam logic [31:0] CrcPoly = 32'hEDB88320;

  // Configuration registers
  logic [24:0] exp_size_q, part_size_q;
  logic [3:0]  wb_bytes_q;
  logic [7:0]  erased_q;

  // Session state
  logic        active_q, active_d;
  logic        init_q, init_d;
  logic [24:0] count_q, count_d;
  logic [31:0] crc_q, crc_d;
  logic [63:0] buf_q, buf_d;
  logic [3:0]  bfill_q, bfill_d;
  logic        dirty_q, dirty_d;
  logic [23:0] bstart_q, bstart_d;
  logic [3:0]  unit_q, unit_d;

  logic        in_fire;
  logic        q_space;
  push_t       push;

  logic [15:0] unit_ok_mask;
  logic        size_bad;
  logic [25:0] cap;
  logic        part_le_md;
  logic        meta_oob;

  logic [63:0] data_buf;
  logic [3:0]  data_fill;
  logic [23:0] data_start;
  logic [31:0] data_crc;

  logic [63:0] fl_buf;
  logic [3:0]  fl_fill;
  logic [23:0] fl_start;
  logic [25:0] fl_off;
  logic [25:0] fl_end;
  logic        fl_oob;
  logic [63:0] fl_data;

  res_t        res_fail;
  res_t        res_stat_bad;
  res_t        res_write;
  res_t        res_commit;

  // Update CRC-32 (reflected) with one byte
  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return ~c;
  endfunction

  // Pad a block with erased bytes up to the program unit
  function automatic logic [63:0] pad_block(logic [63:0] bytes, logic [3:0] fill,
                                            logic [3:0] unit, logic [7:0] erased);
    logic [63:0] d;
    d = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < unit) begin
        d[8*i +: 8] = (4'(i) < fill) ? bytes[8*i +: 8] : erased;
      end
    end
    return d;
  endfunction

  // Program units that are in range and divide the metadata size
  for (genvar g = 0; g < 16; g++) begin : g_unit
    localparam bit UnitOk = (g != 0) && (g <= MAX_BLOCK_BYTES) &&
                            ((METADATA_BYTES % ((g == 0) ? 1 : g)) == 0);
    assign unit_ok_mask[g] = UnitOk;
  end

  assign in_ready_o = q_space;
  assign in_fire    = in_valid_i && in_ready_o;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_size_q  <= '0;
      part_size_q <= '0;
      wb_bytes_q  <= 4'd4;
      erased_q    <= 8'hFF;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_EXPECTED_SIZE:  exp_size_q  <= cfg_wdata_i;
        CFG_PARTITION_SIZE: part_size_q <= cfg_wdata_i;
        CFG_WRITE_BLOCK:    wb_bytes_q  <= cfg_wdata_i[3:0];
        CFG_ERASED_FILL:    erased_q    <= cfg_wdata_i[7:0];
        default:            exp_size_q  <= exp_size_q;
      endcase
    end
  end

  // Size checks against the partition
  assign part_le_md = ({1'b0, part_size_q} <= MdW);
  assign cap        = {1'b0, part_size_q} - MdW;
  assign size_bad   = (exp_size_q == '0) || part_le_md || ({1'b0, exp_size_q} > cap);
  assign meta_oob   = (MdW > {1'b0, part_size_q});

  // Add the incoming byte to the open block
  always_comb begin
    logic [63:0] base_buf;
    logic [3:0]  base_fill;
    base_buf   = dirty_q ? buf_q : '0;
    base_fill  = dirty_q ? bfill_q : '0;
    data_start = dirty_q ? bstart_q : count_q[23:0];
    data_buf   = base_buf | ({56'd0, in_data_i.data_byte} << {base_fill[2:0], 3'b000});
    data_fill  = base_fill + 4'd1;
    data_crc   = crc32_byte(crc_q, in_data_i.data_byte);
  end

  // Flush the open block: pad and range check
  always_comb begin
    if (in_data_i.mode == MODE_DATA) begin
      fl_buf   = data_buf;
      fl_fill  = data_fill;
      fl_start = data_start;
    end else begin
      fl_buf   = buf_q;
      fl_fill  = bfill_q;
      fl_start = bstart_q;
    end
    fl_off  = MdW + {2'd0, fl_start};
    fl_end  = fl_off + {22'd0, unit_q};
    fl_oob  = (fl_end > {1'b0, part_size_q});
    fl_data = pad_block(fl_buf, fl_fill, unit_q, erased_q);
  end

  // Result templates
  always_comb begin
    res_fail            = '0;
    res_fail.kind       = init_q ? KIND_ERASE_META : KIND_STATUS;
    res_stat_bad        = '0;
    res_stat_bad.kind   = KIND_STATUS;
    res_write           = '0;
    res_write.kind      = KIND_WRITE;
    res_write.flash_offset = fl_off[23:0];
    res_write.block_data   = fl_data;
    res_write.ok        = 1'b1;
    res_commit          = '0;
    res_commit.kind     = KIND_COMMIT;
    res_commit.image_size = count_q;
    res_commit.image_crc  = crc_q;
    res_commit.ok       = 1'b1;
  end

  // Decode one request into state updates and results
  always_comb begin
    logic clear;
    active_d = active_q;
    init_d   = init_q;
    count_d  = count_q;
    crc_d    = crc_q;
    buf_d    = buf_q;
    bfill_d  = bfill_q;
    dirty_d  = dirty_q;
    bstart_d = bstart_q;
    unit_d   = unit_q;
    clear    = 1'b0;
    push     = '0;

    if (in_fire) begin
      unique case (in_data_i.mode)
        MODE_BEGIN: begin
          push.cnt = 2'd1;
          if (size_bad || (!init_q && !unit_ok_mask[wb_bytes_q])) begin
            push.r0 = res_stat_bad;
          end else begin
            if (!init_q) begin
              init_d = 1'b1;
              unit_d = wb_bytes_q;
            end
            push.r0      = '0;
            push.r0.kind = KIND_ERASE_PART;
            push.r0.ok   = 1'b1;
            clear        = 1'b1;
          end
        end
        MODE_DATA: begin
          push.cnt = 2'd1;
          if (!active_q) begin
            push.r0 = res_stat_bad;
          end else if (count_q >= exp_size_q) begin
            push.r0 = res_fail;
            clear   = 1'b1;
          end else if (data_fill >= unit_q) begin
            if (fl_oob) begin
              push.r0 = res_fail;
              clear   = 1'b1;
            end else begin
              push.r0  = res_write;
              count_d  = count_q + 25'd1;
              crc_d    = data_crc;
              buf_d    = '0;
              bfill_d  = '0;
              dirty_d  = 1'b0;
              bstart_d = '0;
            end
          end else begin
            push.r0      = '0;
            push.r0.kind = KIND_STATUS;
            push.r0.ok   = 1'b1;
            count_d      = count_q + 25'd1;
            crc_d        = data_crc;
            buf_d        = data_buf;
            bfill_d      = data_fill;
            dirty_d      = 1'b1;
            bstart_d     = data_start;
          end
        end
        MODE_FINISH: begin
          push.cnt = 2'd1;
          if (!active_q || (count_q != exp_size_q)) begin
            push.r0 = res_fail;
            clear   = 1'b1;
          end else if (dirty_q) begin
            if (fl_oob) begin
              push.r0 = res_fail;
              clear   = 1'b1;
            end else begin
              push.cnt = 2'd2;
              push.r0  = res_write;
              buf_d    = '0;
              bfill_d  = '0;
              dirty_d  = 1'b0;
              bstart_d = '0;
              if (meta_oob) begin
                push.r1 = res_fail;
                clear   = 1'b1;
              end else begin
                push.r1  = res_commit;
                active_d = 1'b0;
              end
            end
          end else if (meta_oob) begin
            push.r0 = res_fail;
            clear   = 1'b1;
          end else begin
            push.r0  = res_commit;
            active_d = 1'b0;
          end
        end
        MODE_ABORT: begin
          push.cnt = 2'd1;
          push.r0  = res_fail;
          clear    = 1'b1;
        end
        default: begin
          push.cnt = 2'd0;
        end
      endcase

      // Drop the session; a successful begin reopens it
      if (clear) begin
        active_d = (in_data_i.mode == MODE_BEGIN);
        count_d  = '0;
        crc_d    = '0;
        buf_d    = '0;
        bfill_d  = '0;
        dirty_d  = 1'b0;
        bstart_d = '0;
      end

      // Mark the final result of this request
      if (push.cnt == 2'd2) begin
        push.r1.last = 1'b1;
      end else begin
        push.r0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      init_q   <= 1'b0;
      count_q  <= '0;
      crc_q    <= '0;
      buf_q    <= '0;
      bfill_q  <= '0;
      dirty_q  <= 1'b0;
      bstart_q <= '0;
      unit_q   <= '0;
    end else begin
      active_q <= active_d;
      init_q   <= init_d;
      count_q  <= count_d;
      crc_q    <= crc_d;
      buf_q    <= buf_d;
      bfill_q  <= bfill_d;
      dirty_q  <= dirty_d;
      bstart_q <= bstart_d;
      unit_q   <= unit_d;
    end
  end

  // Hold results until the sink takes them
  fbs_res_queue u_res_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (q_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `FBS_ASSERT(a_active_init, !active_q || init_q, "session open without initialized area")
  `FBS_ASSERT_NEXT(a_init_sticky, init_q, init_q, "area initialized flag dropped")
  `FBS_ASSERT(a_open_block, !dirty_q || ((bfill_q != 4'd0) && (bfill_q < unit_q)),
              "open block fill outside program unit")

endmodule

`default_nettype wire

// ----- hw/rtl/fbs_res_queue.sv -----
// ----------------------------------------------------------------------------
// Flash block stager result queue
// Small register queue that takes zero to two results per cycle and hands
// out one per cycle while the sink is ready; it advertises space only when two slots are free.
// ----------------------------------------------------------------------------
`default_nettype none
`include "flash_block_stager_crc32_defines.svh"

module fbs_res_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fbs_pkg::push_t push_i,
  output logic           space_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output fbs_pkg::res_t  out_data_o
);
  import fbs_pkg::*;

  res_t              mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              pop;
  logic [QPtrW-1:0]  wr_ptr_nx;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign space_o     = (cnt_q <= QCntW'(QDepth - 2));
  assign wr_ptr_nx   = wr_ptr_q + QPtrW'(1);

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q + QPtrW'(push_i.cnt);
    rd_ptr_d = pop ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCntW'(push_i.cnt) - QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store incoming results
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.r1;
    end
  end

  `FBS_ASSERT(a_cnt_bound, cnt_q <= QCntW'(QDepth), "result queue overfilled")
  `FBS_ASSERT(a_push_space, (push_i.cnt == 2'd0) || (cnt_q <= QCntW'(QDepth - 2)),
              "results pushed without room")
  `FBS_ASSERT_NEXT(a_pop_drain, pop && (push_i.cnt == 2'd0), cnt_q == $past(cnt_q) - 1'b1,
                   "pop did not drain an entry")

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flash block stager testbench
// Drives staging sessions (begin, image bytes, finish, abort) into the stager
// with random sender bursts and receiver stalls. A scoreboard predicts the
// erase, write, commit and status results and checks each one field by field.
// ----------------------------------------------------------------------------

import fbs_pkg::*;

class stager_scoreboard;

  localparam int unsigned MetaBytes = 256;

  // Register copies
  logic [24:0] exp_size;
  logic [24:0] part_size;
  logic [3:0]  unit_reg;
  logic [7:0]  pad_byte;

  // Session state
  bit          active;
  bit          area_ready;
  int unsigned unit_len;
  logic [24:0] byte_count;
  logic [31:0] crc_acc;
  logic [63:0] blk_bytes;
  int unsigned blk_fill;
  bit          blk_dirty;
  logic [23:0] blk_start;

  res_t        batch[$];
  res_t        pending_results[$];
  int          errors;

  function new();
    exp_size   = '0;
    part_size  = '0;
    unit_reg   = 4'd4;
    pad_byte   = 8'hFF;
    area_ready = 1'b0;
    unit_len   = 0;
    errors     = 0;
    clear_session();
  endfunction

  function void set_reg(cfg_idx_e idx, logic [24:0] val);
    case (idx)
      CFG_EXPECTED_SIZE:  exp_size = val;
      CFG_PARTITION_SIZE: part_size = val;
      CFG_WRITE_BLOCK:    unit_reg = val[3:0];
      default:            pad_byte = val[7:0];
    endcase
  endfunction

  function void clear_session();
    active     = 1'b0;
    byte_count = '0;
    crc_acc    = '0;
    blk_bytes  = '0;
    blk_fill   = 0;
    blk_dirty  = 1'b0;
    blk_start  = '0;
  endfunction

  function void add_result(kind_e k, logic [23:0] off, logic [63:0] data,
                           logic [24:0] size, logic [31:0] crc, bit ok);
    res_t r;
    r              = '0;
    r.kind         = k;
    r.flash_offset = off;
    r.block_data   = data;
    r.image_size   = size;
    r.image_crc    = crc;
    r.ok           = ok;
    batch.push_back(r);
  endfunction

  // Erase the metadata sector once the area exists, then drop the session
  function void fail_session();
    add_result(area_ready ? KIND_ERASE_META : KIND_STATUS, '0, '0, '0, '0, 1'b0);
    clear_session();
  endfunction

  // Emit the open block padded to the program unit; -1 if it leaves the partition
  function int flush_block();
    logic [63:0] data;
    logic [63:0] off;
    if (!blk_dirty) return 0;
    data = '0;
    for (int i = 0; i < unit_len && i < 8; i++) begin
      data[8*i +: 8] = (i < blk_fill) ? blk_bytes[8*i +: 8] : pad_byte;
    end
    off = 64'(MetaBytes) + 64'(blk_start);
    if (off > 64'(part_size) || 64'(unit_len) > 64'(part_size) - off) return -1;
    add_result(KIND_WRITE, off[23:0], data, '0, '0, 1'b1);
    blk_bytes = '0;
    blk_fill  = 0;
    blk_dirty = 1'b0;
    blk_start = '0;
    return 1;
  endfunction

  // Predict the results of one accepted request and queue them
  function void note_request(req_t rq);
    logic [24:0] cap;
    logic [31:0] c;
    bit          good;
    res_t        r;
    batch.delete();
    case (rq.mode)
      MODE_BEGIN: begin
        cap = (part_size <= 25'(MetaBytes)) ? '0 : part_size - 25'(MetaBytes);
        if (exp_size == 0 || exp_size > cap) begin
          add_result(KIND_STATUS, '0, '0, '0, '0, 1'b0);
        end else begin
          good = 1'b1;
          if (!area_ready) begin
            if (unit_reg == 0 || unit_reg > 8 || (MetaBytes % unit_reg) != 0) begin
              good = 1'b0;
            end else begin
              unit_len   = 32'(unit_reg);
              area_ready = 1'b1;
            end
          end
          if (!good) begin
            add_result(KIND_STATUS, '0, '0, '0, '0, 1'b0);
          end else begin
            add_result(KIND_ERASE_PART, '0, '0, '0, '0, 1'b1);
            clear_session();
            active = 1'b1;
          end
        end
      end
      MODE_DATA: begin
        if (!active) begin
          add_result(KIND_STATUS, '0, '0, '0, '0, 1'b0);
        end else if (byte_count >= exp_size) begin
          fail_session();
        end else begin
          if (!blk_dirty) begin
            blk_start = byte_count[23:0];
            blk_fill  = 0;
            blk_bytes = '0;
            blk_dirty = 1'b1;
          end
          blk_bytes[8*(blk_fill & 7) +: 8] = rq.data_byte;
          blk_fill = blk_fill + 1;
          // Reflected CRC-32, one bit per step
          c = ~crc_acc ^ {24'd0, rq.data_byte};
          for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (32'hEDB88320 & {32{c[0]}});
          end
          crc_acc    = ~c;
          byte_count = byte_count + 25'd1;
          if (blk_fill >= unit_len) begin
            if (flush_block() < 0) fail_session();
          end else begin
            add_result(KIND_STATUS, '0, '0, '0, '0, 1'b1);
          end
        end
      end
      MODE_FINISH: begin
        if (!active || byte_count != exp_size) begin
          fail_session();
        end else if (flush_block() < 0) begin
          fail_session();
        end else if (25'(MetaBytes) > part_size) begin
          fail_session();
        end else begin
          add_result(KIND_COMMIT, '0, '0, byte_count, crc_acc, 1'b1);
          active = 1'b0;
        end
      end
      default: fail_session();
    endcase
    // Mark the final result of this request
    r = batch[batch.size()-1];
    r.last = 1'b1;
    batch[batch.size()-1] = r;
    foreach (batch[i]) pending_results.push_back(batch[i]);
  endfunction

  function void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(res_t got);
    res_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result: kind %0d, offset 0x%0h", got.kind, got.flash_offset);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    check_field("kind", want.kind, got.kind);
    check_field("flash_offset", want.flash_offset, got.flash_offset);
    check_field("block_data", want.block_data, got.block_data);
    check_field("image_size", want.image_size, got.image_size);
    check_field("image_crc", want.image_crc, got.image_crc);
    check_field("ok", want.ok, got.ok);
    check_field("last", want.last, got.last);
  endfunction

endclass

module tb;

  localparam int unsigned StallLimit = 3000;
  localparam int unsigned NumPhases  = 10;
  localparam int unsigned PhaseItems = 45;
  localparam logic [24:0] MaxSize    = 25'd16777216;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  req_t                  in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  res_t                  out_data_o;
  logic                  cfg_we_i;
  cfg_idx_e              cfg_index_i;
  logic [CfgWidth-1:0]   cfg_wdata_i;

  stager_scoreboard sb = new();

  int unsigned burst_left;
  int unsigned sent_requests;
  int unsigned stall_cycles;
  int unsigned prog_unit;
  logic [24:0] cur_esize;

  flash_block_stager_crc32 u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: alternate between steady, random and mostly stalled stretches
  initial begin
    int unsigned style;
    int unsigned len;
    out_ready_i = 1'b0;
    forever begin
      style = $urandom_range(0, 3);
      len   = $urandom_range(10, 80);
      repeat (len) begin
        @(negedge clk_i);
        case (style)
          0:       out_ready_i = 1'b1;
          1:       out_ready_i = 1'($urandom_range(0, 1));
          2:       out_ready_i = ($urandom_range(0, 7) != 0);
          default: out_ready_i = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Present one request, holding it until accepted; called at a falling edge
  task automatic send(input mode_e mode, input logic [7:0] data);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 5);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_data_i.mode      = mode;
    in_data_i.data_byte = data;
    in_valid_i          = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(in_data_i);
    sent_requests++;
    burst_left--;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic settle();
    in_valid_i = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // Write one register while the block is idle
  task automatic write_reg(input cfg_idx_e idx, input logic [24:0] val);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    if (idx == CFG_EXPECTED_SIZE) cur_esize = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Pick new register values for a random phase
  task automatic configure_phase();
    int unsigned pick;
    logic [24:0] esize;
    logic [24:0] psize;
    settle();
    pick = $urandom_range(0, 9);
    if (pick == 0) esize = '0;
    else if (pick < 3) esize = 25'($urandom_range(25, 60));
    else esize = 25'($urandom_range(1, 3 * prog_unit + 2));
    write_reg(CFG_EXPECTED_SIZE, esize);
    pick = $urandom_range(0, 9);
    case (pick)
      0:       psize = $urandom_range(0, 1) ? MaxSize : '0;
      1:       psize = 25'($urandom_range(0, 300));
      2, 3:    psize = 25'd256 + esize + 25'($urandom_range(0, prog_unit - 1));
      4, 5:    psize = MaxSize - 25'($urandom_range(0, 4096));
      default: psize = 25'd256 + esize + 25'($urandom_range(prog_unit, 1000));
    endcase
    write_reg(CFG_PARTITION_SIZE, psize);
    // The program unit is latched already; these writes must not matter
    if ($urandom_range(0, 1)) write_reg(CFG_WRITE_BLOCK, 25'($urandom_range(0, 15)));
    if ($urandom_range(0, 1)) begin
      pick = $urandom_range(0, 3);
      write_reg(CFG_ERASED_FILL, (pick == 0) ? 25'd0 : (pick == 1) ? 25'd255 :
                                 25'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int unsigned phase_start;
    int unsigned pick;
    int unsigned nbytes;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_EXPECTED_SIZE;
    cfg_wdata_i   = '0;
    burst_left    = 0;
    sent_requests = 0;
    stall_cycles  = 0;
    cur_esize     = '0;
    prog_unit     = 2 << $urandom_range(0, 2);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Nothing open yet: data, finish and abort are rejected, zero size too
    send(MODE_DATA, 8'hA5);
    send(MODE_FINISH, 8'h00);
    send(MODE_ABORT, 8'h00);
    send(MODE_BEGIN, 8'h00);
    settle();
    // Size above the partition capacity
    write_reg(CFG_PARTITION_SIZE, MaxSize);
    write_reg(CFG_EXPECTED_SIZE, MaxSize);
    send(MODE_BEGIN, 8'h00);
    settle();
    // Largest legal size, with bad program units first
    write_reg(CFG_EXPECTED_SIZE, MaxSize - 25'd256);
    write_reg(CFG_WRITE_BLOCK, 25'd0);
    send(MODE_BEGIN, 8'h00);
    settle();
    write_reg(CFG_WRITE_BLOCK, 25'd3);
    send(MODE_BEGIN, 8'h00);
    settle();
    write_reg(CFG_WRITE_BLOCK, 25'd15);
    send(MODE_BEGIN, 8'h00);
    settle();
    write_reg(CFG_WRITE_BLOCK, 25'(prog_unit));
    send(MODE_BEGIN, 8'h00);
    send(MODE_DATA, 8'h00);
    send(MODE_DATA, 8'hFF);
    // Restart during a session, then abort it
    send(MODE_BEGIN, 8'h00);
    send(MODE_ABORT, 8'h00);
    settle();
    // Padded block at finish runs past the partition end
    write_reg(CFG_EXPECTED_SIZE, 25'd1);
    write_reg(CFG_PARTITION_SIZE, 25'd257);
    send(MODE_BEGIN, 8'h00);
    send(MODE_DATA, 8'h3C);
    send(MODE_FINISH, 8'h00);
    settle();
    // Clean session with zero padding, then data after the commit
    write_reg(CFG_PARTITION_SIZE, MaxSize);
    write_reg(CFG_EXPECTED_SIZE, 25'd3);
    write_reg(CFG_ERASED_FILL, 25'd0);
    send(MODE_BEGIN, 8'h00);
    send(MODE_DATA, 8'h5A);
    send(MODE_DATA, 8'hFF);
    send(MODE_DATA, 8'h00);
    send(MODE_FINISH, 8'h00);
    send(MODE_DATA, 8'h11);
    settle();
    // One byte too many
    write_reg(CFG_EXPECTED_SIZE, 25'd1);
    send(MODE_BEGIN, 8'h00);
    send(MODE_DATA, 8'h77);
    send(MODE_DATA, 8'h88);
    send(MODE_BEGIN, 8'h00);
    settle();
    // Partition shrinks below the metadata area before finish
    write_reg(CFG_EXPECTED_SIZE, 25'd0);
    write_reg(CFG_PARTITION_SIZE, 25'd100);
    send(MODE_FINISH, 8'h00);

    // Random phases: mostly well-formed sessions, some noise
    for (int p = 0; p < NumPhases; p++) begin
      configure_phase();
      phase_start = sent_requests;
      // Sometimes continue a session left open under the new settings
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, prog_unit)) send(MODE_DATA, 8'($urandom_range(0, 255)));
        send(MODE_FINISH, 8'($urandom_range(0, 255)));
      end
      while (sent_requests - phase_start < PhaseItems) begin
        if ($urandom_range(0, 9) < 8) begin
          pick = $urandom_range(0, 19);
          if (pick < 15) nbytes = 32'(cur_esize);
          else if (pick < 17) nbytes = 32'(cur_esize) + 1;
          else if (pick == 17 && cur_esize > 0) nbytes = 32'(cur_esize) - 1;
          else nbytes = $urandom_range(0, 32'(cur_esize) + 2);
          send(MODE_BEGIN, 8'($urandom_range(0, 255)));
          repeat (nbytes) send(MODE_DATA, 8'($urandom_range(0, 255)));
          pick = $urandom_range(0, 19);
          if (pick < 16) send(MODE_FINISH, 8'($urandom_range(0, 255)));
          else if (pick < 19) send(MODE_ABORT, 8'($urandom_range(0, 255)));
        end else begin
          send(mode_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
      end
    end

    // Drain and let the pipeline go quiet
    settle();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/fbs_pkg.sv
hw/rtl/fbs_res_queue.sv
hw/rtl/flash_block_stager_crc32.sv
dv/tb.sv
